FILE: src/kie_pkg.sv
// ----------------------------------------------------------------------------
// kie_pkg
// shared constants and codes for the 2-d k-means iteration engine
// ----------------------------------------------------------------------------
package kie_pkg;

    // coordinate format, fixed by the item fields
    localparam int COORD_BITS   = 16;
    // centroid storage depth, fixed by the 3-bit slot and index fields
    localparam int MAX_CLUSTERS = 8;
    localparam int IDX_W        = $clog2(MAX_CLUSTERS);
    // default saturation limit for per-cluster membership counts
    localparam int MAX_POINTS_DEF = 256;

    // config port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_CLUSTER_COUNT = 1'b0;
    localparam logic [3:0] CLUSTER_COUNT_RESET = 4'd6;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ASSIGN = 2'd1,
        CMD_UPDATE = 2'd2
    } t_command;

    localparam logic KIND_ASSIGN   = 1'b0;
    localparam logic KIND_CENTROID = 1'b1;

endpackage

FILE: src/kmeans_iteration_engine.sv
// ----------------------------------------------------------------------------
// kmeans_iteration_engine
// one lloyd iteration of 2-d k-means over command items: load centroid,
// assign point (nearest centroid plus accumulation), update all active centroids
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  command   | in        | start high while busy low   | command, slot, coord_x/y
//  result    | out       | o_result_strobe, one cycle  | kind, cluster_index,
//            |           |                             | new_x/y, last
//  config    | in/out    | apb write, pready always 1  | cluster_count at 0x0
//
//  load: taken in the accept cycle, busy stays low
//  assign: one shared squarer walks centroids in turn (SQX, SQY, CMP), then ACC
//  update: per centroid DIV_START then EMIT, with DIV_START and DIV per axis
//  when members exist; one shared restoring divider does x then y a bit per cycle
//  reset is synchronous and clears centroids, sums and counts;
//  results cannot be stalled, each strobe lasts exactly one cycle
// ----------------------------------------------------------------------------
module kmeans_iteration_engine #(
    parameter int MAX_POINTS = kie_pkg::MAX_POINTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_command,
    input  logic [2:0]                             i_slot,
    input  logic signed [kie_pkg::COORD_BITS-1:0]  i_coord_x,
    input  logic signed [kie_pkg::COORD_BITS-1:0]  i_coord_y,
    // result channel
    output logic                                   o_result_strobe,
    output logic                                   o_kind,
    output logic [2:0]                             o_cluster_index,
    output logic signed [kie_pkg::COORD_BITS-1:0]  o_new_x,
    output logic signed [kie_pkg::COORD_BITS-1:0]  o_new_y,
    output logic                                   o_last,
    // config port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [kie_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [kie_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [kie_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import kie_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ACC_W  = COORD_BITS + $clog2(MAX_POINTS) + 1;
    localparam int STEP_W = $clog2(ACC_W);
    localparam int D_W    = 2 * COORD_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_CMP,
        S_ACC,
        S_DIV_START,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [3:0]              r_cluster_count;

    logic signed [C-1:0]     r_cx [MAX_CLUSTERS];
    logic signed [C-1:0]     r_cy [MAX_CLUSTERS];
    logic signed [ACC_W-1:0] r_ax [MAX_CLUSTERS];
    logic signed [ACC_W-1:0] r_ay [MAX_CLUSTERS];
    logic [CNT_W-1:0]        r_cnt [MAX_CLUSTERS];

    logic signed [C-1:0]     r_px;
    logic signed [C-1:0]     r_py;
    logic [IDX_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_best;
    logic [D_W-1:0]          r_best_d;
    logic [2*C-1:0]          r_dist;
    logic [2*C-1:0]          r_sq;
    logic signed [C:0]       r_diff_x;
    logic signed [C:0]       r_diff_y;

    logic [CNT_W-1:0]        r_rem;
    logic [ACC_W-1:0]        r_quo;
    logic                    r_neg;
    logic [STEP_W-1:0]       r_step;
    logic                    r_axis;

    logic                    r_strobe;
    logic                    r_kind;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [C-1:0]     r_out_x;
    logic signed [C-1:0]     r_out_y;
    logic                    r_out_last;

    // ---------------------------------------------------------------- config
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_CLUSTER_COUNT)
                  ? CFG_DATA_W'(r_cluster_count) : '0;

    // cluster count clamped to 1..MAX_CLUSTERS, as last index
    logic [IDX_W-1:0] last_idx;
    always_comb begin
        if (r_cluster_count == 4'd0) begin
            last_idx = '0;
        end else if (r_cluster_count > 4'(MAX_CLUSTERS)) begin
            last_idx = IDX_W'(MAX_CLUSTERS - 1);
        end else begin
            last_idx = IDX_W'(r_cluster_count - 4'd1);
        end
    end

    // ---------------------------------------------------------- shared squarer
    logic signed [C:0]       mul_in;
    logic signed [2*C+1:0]   mul_full;
    logic [2*C-1:0]          sq;
    assign mul_in   = (r_state == S_SQX) ? r_diff_x : r_diff_y;
    assign mul_full = mul_in * mul_in;
    assign sq       = mul_full[2*C-1:0];

    logic [D_W-1:0]   dist_sum;
    logic [IDX_W-1:0] k_next;
    assign dist_sum = {1'b0, r_dist} + {1'b0, r_sq};
    assign k_next   = r_k + 1'b1;

    // -------------------------------------------------------- shared divider
    logic [CNT_W-1:0]        divisor;
    logic signed [ACC_W-1:0] div_src;
    logic [CNT_W:0]          div_t;
    logic                    div_ge;
    logic [CNT_W:0]          div_sub;
    logic [ACC_W-1:0]        div_q;
    logic [ACC_W-1:0]        div_res;
    logic [CNT_W-1:0]        sel_cnt;
    logic [IDX_W-1:0]        sel_idx;

    assign sel_idx = (r_state == S_ACC) ? r_best : r_k;
    assign sel_cnt = r_cnt[sel_idx];
    assign divisor = sel_cnt;
    assign div_src = r_axis ? r_ay[r_k] : r_ax[r_k];
    assign div_t   = {r_rem, r_quo[ACC_W-1]};
    assign div_ge  = div_t >= {1'b0, divisor};
    assign div_sub = div_t - {1'b0, divisor};
    assign div_q   = {r_quo[ACC_W-2:0], div_ge};
    assign div_res = r_neg ? (~div_q + 1'b1) : div_q;

    logic cmd_accept;
    assign cmd_accept = start && !busy;

    // ---------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cluster_count <= CLUSTER_COUNT_RESET;
            r_strobe        <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                r_cx[i]  <= '0;
                r_cy[i]  <= '0;
                r_ax[i]  <= '0;
                r_ay[i]  <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            if (cfg_wr && paddr[2] == CFG_IDX_CLUSTER_COUNT) begin
                r_cluster_count <= pwdata[3:0];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (cmd_accept) begin
                        unique case (i_command)
                            CMD_LOAD: begin
                                if ({1'b0, i_slot} < 4'(MAX_CLUSTERS)) begin
                                    r_cx[IDX_W'(i_slot)] <= i_coord_x;
                                    r_cy[IDX_W'(i_slot)] <= i_coord_y;
                                end
                            end
                            CMD_ASSIGN: begin
                                r_px     <= i_coord_x;
                                r_py     <= i_coord_y;
                                r_k      <= '0;
                                r_diff_x <= {i_coord_x[C-1], i_coord_x}
                                          - {r_cx[0][C-1], r_cx[0]};
                                r_diff_y <= {i_coord_y[C-1], i_coord_y}
                                          - {r_cy[0][C-1], r_cy[0]};
                                r_state  <= S_SQX;
                            end
                            CMD_UPDATE: begin
                                r_k     <= '0;
                                r_axis  <= 1'b0;
                                r_state <= S_DIV_START;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_SQX: begin
                    r_dist  <= sq;
                    r_state <= S_SQY;
                end

                S_SQY: begin
                    r_sq    <= sq;
                    r_state <= S_CMP;
                end

                S_CMP: begin
                    // strict less-than keeps the lowest index on a tie
                    if (r_k == '0 || dist_sum < r_best_d) begin
                        r_best   <= r_k;
                        r_best_d <= dist_sum;
                    end
                    if (r_k == last_idx) begin
                        r_state <= S_ACC;
                    end else begin
                        r_k      <= k_next;
                        r_diff_x <= {r_px[C-1], r_px} - {r_cx[k_next][C-1], r_cx[k_next]};
                        r_diff_y <= {r_py[C-1], r_py} - {r_cy[k_next][C-1], r_cy[k_next]};
                        r_state  <= S_SQX;
                    end
                end

                S_ACC: begin
                    // full cluster: report but do not accumulate
                    if (sel_cnt < CNT_W'(MAX_POINTS)) begin
                        r_ax[r_best]  <= r_ax[r_best]
                                       + {{(ACC_W-C){r_px[C-1]}}, r_px};
                        r_ay[r_best]  <= r_ay[r_best]
                                       + {{(ACC_W-C){r_py[C-1]}}, r_py};
                        r_cnt[r_best] <= sel_cnt + 1'b1;
                    end
                    r_strobe   <= 1'b1;
                    r_kind     <= KIND_ASSIGN;
                    r_out_idx  <= r_best;
                    r_out_x    <= '0;
                    r_out_y    <= '0;
                    r_out_last <= 1'b1;
                    r_state    <= S_IDLE;
                end

                S_DIV_START: begin
                    if (divisor == '0) begin
                        // empty cluster keeps its centroid
                        r_state <= S_EMIT;
                    end else begin
                        r_neg   <= div_src[ACC_W-1];
                        r_quo   <= div_src[ACC_W-1] ? (~div_src + 1'b1) : div_src;
                        r_rem   <= '0;
                        r_step  <= STEP_W'(ACC_W - 1);
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_rem <= div_ge ? div_sub[CNT_W-1:0] : div_t[CNT_W-1:0];
                    r_quo <= div_q;
                    if (r_step == '0) begin
                        if (r_axis) begin
                            r_cy[r_k] <= div_res[C-1:0];
                            r_state   <= S_EMIT;
                        end else begin
                            r_cx[r_k] <= div_res[C-1:0];
                            r_axis    <= 1'b1;
                            r_state   <= S_DIV_START;
                        end
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end

                S_EMIT: begin
                    r_strobe   <= 1'b1;
                    r_kind     <= KIND_CENTROID;
                    r_out_idx  <= r_k;
                    r_out_x    <= r_cx[r_k];
                    r_out_y    <= r_cy[r_k];
                    r_out_last <= (r_k == last_idx);
                    if (r_k == last_idx) begin
                        for (int i = 0; i < MAX_CLUSTERS; i++) begin
                            r_ax[i]  <= '0;
                            r_ay[i]  <= '0;
                            r_cnt[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= k_next;
                        r_axis  <= 1'b0;
                        r_state <= S_DIV_START;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_kind          = r_kind;
    assign o_cluster_index = 3'(r_out_idx);
    assign o_new_x         = r_out_x;
    assign o_new_y         = r_out_y;
    assign o_last          = r_out_last;

`ifndef SYNTHESIS
    a_assign_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_kind == KIND_ASSIGN) |-> o_last)
        else $error("assignment result without last");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without preceding work");

    a_assign_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_ASSIGN) |=> busy)
        else $error("accepted assign did not start the sequencer");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_kind == KIND_CENTROID) |-> r_out_idx <= last_idx)
        else $error("centroid emitted beyond cluster count");
`endif

endmodule
